@@ rtl/rbes_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ring band extent scan.
package rbes_pkg;

  localparam int CNT_W  = 11;
  localparam int GAP_W  = 5;
  localparam int BLUR_W = 4;
  localparam int RLIM_W = 4;
  localparam int STAT_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_UNCLOSED   = 3'd1,
    ST_ZERO_BAND  = 3'd2,
    ST_UNBALANCED = 3'd3,
    ST_RATIO      = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLUR_RADIUS = 2'd0,
    REG_RATIO_LIMIT = 2'd1,
    REG_EDGE_CLOSES = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BLUR_W-1:0] blur_radius;
    logic [RLIM_W-1:0] ratio_limit;
    logic              edge_closes;
  } cfg_t;

  typedef struct packed {
    logic is_red;
    logic scan_side;
    logic first_of_scan;
    logic last_of_scan;
  } item_t;

  typedef struct packed {
    logic [GAP_W-1:0] gap_counter;
    logic [CNT_W-1:0] distance;
    logic [CNT_W-1:0] band_forward;
    logic [CNT_W-1:0] band_backward;
    logic [CNT_W-1:0] extent;
    logic             scan_closed;
  } scan_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] extent;
    logic [CNT_W-1:0] min_band;
    status_t          status;
  } result_t;

endpackage

@@ rtl/rbes_in_if.sv @@
`timescale 1ns / 1ps
// Pixel input channel: valid/ready handshake carrying one mask pixel per beat.
interface rbes_in_if;
  logic valid;
  logic ready;
  logic is_red;
  logic scan_side;
  logic first_of_scan;
  logic last_of_scan;

  modport source (output valid, is_red, scan_side, first_of_scan, last_of_scan,
                  input ready);
  modport sink   (input valid, is_red, scan_side, first_of_scan, last_of_scan,
                  output ready);
endinterface

@@ rtl/rbes_out_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one measurement per beat.
interface rbes_out_if;
  import rbes_pkg::*;
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  extent;
  logic [CNT_W-1:0]  min_band;
  logic [STAT_W-1:0] status;

  modport source (output valid, extent, min_band, status, input ready);
  modport sink   (input valid, extent, min_band, status, output ready);
endinterface

@@ rtl/rbes_step.sv @@
`timescale 1ns / 1ps
// Per-pixel scan update and end-of-scan band checks.
module rbes_step (
  input  rbes_pkg::cfg_t        cfg_i,
  input  rbes_pkg::item_t       item_i,
  input  rbes_pkg::scan_state_t state_i,
  output rbes_pkg::scan_state_t state_o,
  output logic                  emit_o,
  output rbes_pkg::result_t     result_o
);
  import rbes_pkg::*;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Integer quotient tests are done as multiplies: e/x < 2 is e < 2x, and
  // e/x > limit is e >= (limit + 1) * x.
  function automatic status_t judge(input logic [CNT_W-1:0]  e,
                                    input logic [CNT_W-1:0]  f,
                                    input logic [CNT_W-1:0]  b,
                                    input logic [RLIM_W-1:0] rlim);
    logic [RLIM_W:0]        rp1;
    logic [CNT_W+RLIM_W:0]  lim_f;
    logic [CNT_W+RLIM_W:0]  lim_b;
    logic [CNT_W+RLIM_W:0]  e_w;
    logic [CNT_W:0]         f2;
    logic [CNT_W:0]         b2;
    rp1   = {1'b0, rlim} + 1'b1;
    lim_f = (CNT_W+RLIM_W+1)'(rp1) * (CNT_W+RLIM_W+1)'(f);
    lim_b = (CNT_W+RLIM_W+1)'(rp1) * (CNT_W+RLIM_W+1)'(b);
    e_w   = (CNT_W+RLIM_W+1)'(e);
    f2    = {f, 1'b0};
    b2    = {b, 1'b0};
    if (e == '0) begin
      return ST_UNCLOSED;
    end else if (f == '0 || b == '0) begin
      return ST_ZERO_BAND;
    end else if (f2 < {1'b0, b} || b2 < {1'b0, f}) begin
      return ST_UNBALANCED;
    end else if ({1'b0, e} < f2 || e_w >= lim_f || {1'b0, e} < b2 || e_w >= lim_b) begin
      return ST_RATIO;
    end
    return ST_OK;
  endfunction

  always_comb begin
    scan_state_t s;
    logic        closes;
    status_t     st;
    s        = state_i;
    closes   = 1'b0;
    st       = ST_OK;
    emit_o   = 1'b0;
    result_o = '{extent: '0, min_band: '0, status: ST_OK};

    if (item_i.first_of_scan) begin
      s.gap_counter = '0;
      s.distance    = '0;
      s.scan_closed = 1'b0;
      s.band_backward = '0;
      if (!item_i.scan_side) begin
        s.band_forward = '0;
        s.extent       = '0;
      end
    end

    if (!s.scan_closed) begin
      if (item_i.is_red) begin
        s.gap_counter = GAP_W'(1);
        if (!item_i.scan_side) s.band_forward = sat_inc(s.band_forward);
        else                   s.band_backward = sat_inc(s.band_backward);
      end else if (s.gap_counter != '0 && s.gap_counter <= {1'b0, cfg_i.blur_radius} &&
                   !(!item_i.scan_side && item_i.last_of_scan && cfg_i.edge_closes)) begin
        s.gap_counter = s.gap_counter + 1'b1;
      end else if (s.gap_counter != '0) begin
        closes = 1'b1;
      end

      if (closes) begin
        s.scan_closed = 1'b1;
        if (!item_i.scan_side) begin
          s.extent = s.distance;
        end else if (s.extent != '0 && s.distance > s.extent) begin
          s.extent = s.distance;
        end
      end else begin
        s.distance = sat_inc(s.distance);
      end

      if (!item_i.scan_side) begin
        if (!closes && item_i.last_of_scan) begin
          s.scan_closed = 1'b1;
          emit_o   = 1'b1;
          result_o = '{extent: '0, min_band: '0, status: ST_UNCLOSED};
        end
      end else if (closes || item_i.last_of_scan) begin
        st = judge(s.extent, s.band_forward, s.band_backward, cfg_i.ratio_limit);
        s.scan_closed = 1'b1;
        emit_o = 1'b1;
        if (st == ST_OK) begin
          result_o.extent   = s.extent;
          result_o.min_band = (s.band_forward < s.band_backward) ? s.band_forward
                                                                 : s.band_backward;
          result_o.status   = ST_OK;
        end else begin
          result_o = '{extent: '0, min_band: '0, status: st};
        end
      end
    end
    state_o = s;
  end

endmodule

@@ rtl/ring_band_extent_scan.sv @@
`timescale 1ns / 1ps
// Top level of the ring band extent scan: input register, scan update, result register.
//
// One mask pixel is taken per beat and a new pixel can be accepted on every
// cycle unless a pixel that makes a result waits on a full output register. A
// pixel is held in the input register, where the scan counters are updated and,
// at the end of a backward scan, the band checks run in the same cycle; a result
// is then registered in the output register. The scan state register, updated
// once per pixel, sets this rate. At most one result beat follows each pixel.
// Configuration writes take effect on the next cycle and are meant to be made
// while no scan is in flight.
module ring_band_extent_scan (
  input  logic                                clk,
  input  logic                                rst_n,
  rbes_in_if.sink                             in_ch,
  rbes_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [rbes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbes_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rbes_pkg::*;

  cfg_t        cfg_r;
  item_t       item_r;
  logic        item_valid_r;
  scan_state_t state_r;
  scan_state_t state_nxt;
  logic        emit;
  result_t     result_nxt;
  result_t     result_r;
  logic        out_valid_r;
  logic        advance;

  rbes_step u_step (
    .cfg_i    (cfg_r),
    .item_i   (item_r),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .emit_o   (emit),
    .result_o (result_nxt)
  );

  // The held pixel moves on unless it makes a result and the output is full and not taken.
  assign advance      = item_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !item_valid_r || advance;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.extent   = result_r.extent;
  assign out_ch.min_band = result_r.min_band;
  assign out_ch.status   = result_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= '{blur_radius: 4'd2, ratio_limit: 4'd7, edge_closes: 1'b1};
      item_valid_r <= 1'b0;
      state_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_BLUR_RADIUS: cfg_r.blur_radius <= cfg_wdata[BLUR_W-1:0];
          REG_RATIO_LIMIT: cfg_r.ratio_limit <= cfg_wdata[RLIM_W-1:0];
          REG_EDGE_CLOSES: cfg_r.edge_closes <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        item_valid_r <= in_ch.valid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= '{is_red: in_ch.is_red, scan_side: in_ch.scan_side,
                  first_of_scan: in_ch.first_of_scan, last_of_scan: in_ch.last_of_scan};
    end
    if (advance && emit) begin
      result_r <= result_nxt;
    end
  end

endmodule
